@@ sv/mstt_pkg.sv @@
// ----------------------------------------------------------------------------
// mstt_pkg
// Types and codes shared by the timer table controller, datapath and top.
// ----------------------------------------------------------------------------
package mstt_pkg;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        K_STARTED   = 3'd0,
        K_NOFREE    = 3'd1,
        K_CANCELLED = 3'd2,
        K_REJECTED  = 3'd3,
        K_EXPIRED   = 3'd4,
        K_TICKDONE  = 3'd5
    } t_kind;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] timeout_ms;
        logic [31:0] period_ms;
        logic [3:0]  slot_sel;
        logic [31:0] elapsed_ms;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [31:0] next_wakeup_ms;
        logic        wakeup_valid;
        logic        last;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input beat
        logic scan;      // process the slot at the scan index
        logic scan_clr;  // reset scan index and accumulators
        logic emit_one;  // emit start/cancel result
        logic pick;      // select next expired slot (sweep pass)
        logic emit_exp;  // emit expired result for picked slot
        logic emit_done; // emit tick done
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic scan_end;   // scan index at last slot
        logic any_exp;    // pending expired slot remains
    } t_sts;

endpackage

@@ sv/mstt_ctrl.sv @@
// ----------------------------------------------------------------------------
// mstt_ctrl
// Sequencer: one-shot commands, tick subtract pass, expiry emit passes,
// wakeup minimum pass.
// ----------------------------------------------------------------------------
module mstt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_cmd,
    input  mstt_pkg::t_sts i_sts,
    output mstt_pkg::t_ctl o_ctl,
    output logic           o_busy
);
    import mstt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ONE  = 7'b0000010,
        S_SUB  = 7'b0000100,
        S_PICK = 7'b0001000,
        S_EMIT = 7'b0010000,
        S_MIN  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load     = 1'b1;
                    o_ctl.scan_clr = 1'b1;
                    if (i_cmd == CMD_START || i_cmd == CMD_CANCEL) begin
                        n_state = S_ONE;
                    end else if (i_cmd == CMD_TICK) begin
                        n_state = S_SUB;
                    end
                end
            end
            S_ONE: begin
                o_ctl.emit_one = 1'b1;
                n_state = S_IDLE;
            end
            S_SUB: begin
                o_ctl.scan = 1'b1;
                if (i_sts.scan_end) begin
                    o_ctl.scan_clr = 1'b1;
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                // sweep all slots for the smallest pending (before, slot)
                o_ctl.pick = 1'b1;
                if (i_sts.scan_end) begin
                    o_ctl.scan_clr = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.any_exp) begin
                    o_ctl.emit_exp = 1'b1;
                    n_state = S_PICK;
                end else begin
                    n_state = S_MIN;
                end
            end
            S_MIN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_ctl.emit_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ sv/mstt_dp.sv @@
// ----------------------------------------------------------------------------
// mstt_dp
// Slot store and one-slot-per-cycle tick arithmetic.
// ----------------------------------------------------------------------------
module mstt_dp #(
    parameter int NUM_SLOTS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mstt_pkg::t_in  i_in,
    input  mstt_pkg::t_ctl i_ctl,
    output mstt_pkg::t_sts o_sts,
    output logic           o_valid,
    output mstt_pkg::t_out o_res
);
    import mstt_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [31:0]          r_rem [NUM_SLOTS];
    logic [31:0]          r_per [NUM_SLOTS];
    logic [31:0]          r_bef [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_busy;
    logic [NUM_SLOTS-1:0] r_exp;
    t_in                  r_in;
    logic [IW-1:0]        r_idx;
    logic                 r_phase_min;
    logic [31:0]          r_wake;
    logic                 r_wvalid;
    logic                 r_have;
    logic [IW-1:0]        r_best;
    logic [31:0]          r_bestv;
    logic                 o_valid_r;
    t_out                 r_res;

    logic [IW-1:0] free_idx;
    logic          free_any;
    logic [IW:0]   sel_ext;
    logic          sel_ok;
    logic [31:0]   cur, sub, newv;

    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_idx = IW'(i);
                free_any = 1'b1;
            end
        end
    end

    assign sel_ext = (IW + 1)'(r_in.slot_sel);
    assign sel_ok  = ({28'd0, r_in.slot_sel} < 32'(NUM_SLOTS))
                     && r_busy[sel_ext[IW-1:0]];
    assign cur  = r_rem[r_idx];
    assign sub  = (r_in.elapsed_ms < cur) ? r_in.elapsed_ms : cur;
    assign newv = cur - sub;

    assign o_sts.scan_end = (r_idx == IW'(NUM_SLOTS - 1));
    assign o_sts.any_exp  = r_have;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= '0;
            r_exp     <= '0;
            o_valid_r <= 1'b0;
            r_idx     <= '0;
            r_phase_min <= 1'b0;
            r_have    <= 1'b0;
        end else begin
            o_valid_r <= i_ctl.emit_exp | i_ctl.emit_one | i_ctl.emit_done;
            if (i_ctl.load) begin
                r_in        <= i_in;
                r_phase_min <= 1'b0;
                r_exp       <= '0;
                r_wake      <= '0;
                r_wvalid    <= 1'b0;
            end
            if (i_ctl.scan_clr) begin
                r_idx <= '0;
                if (!i_ctl.load && !i_ctl.pick) r_phase_min <= ~r_phase_min;
            end else if (i_ctl.scan || i_ctl.pick) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_ctl.emit_exp || (i_ctl.scan_clr && !i_ctl.pick)) begin
                r_have <= 1'b0;
            end else if (i_ctl.pick && r_exp[r_idx]) begin
                r_have <= 1'b1;
            end
            if (i_ctl.scan && !r_phase_min && r_busy[r_idx]) begin
                r_bef[r_idx] <= cur;
                r_rem[r_idx] <= newv;
                r_exp[r_idx] <= (newv == 32'd0);
            end
            if (i_ctl.scan && r_phase_min && r_busy[r_idx]) begin
                if (!r_wvalid || cur < r_wake) begin
                    r_wake   <= cur;
                    r_wvalid <= 1'b1;
                end
            end
            if (i_ctl.pick && r_exp[r_idx]) begin
                if (!r_have || r_bef[r_idx] < r_bestv) begin
                    r_best  <= r_idx;
                    r_bestv <= r_bef[r_idx];
                end
            end
            if (i_ctl.emit_exp) begin
                r_exp[r_best] <= 1'b0;
                if (r_per[r_best] != 32'd0) begin
                    r_rem[r_best] <= r_per[r_best];
                end else begin
                    r_busy[r_best] <= 1'b0;
                end
                r_res <= '{K_EXPIRED, 4'(r_best), 32'd0, 1'b0, 1'b0};
            end
            if (i_ctl.emit_one) begin
                if (r_in.cmd == CMD_START) begin
                    if (free_any) begin
                        r_busy[free_idx] <= 1'b1;
                        r_rem[free_idx]  <= r_in.timeout_ms;
                        r_per[free_idx]  <= r_in.period_ms;
                        r_res <= '{K_STARTED, 4'(free_idx), 32'd0, 1'b0, 1'b1};
                    end else begin
                        r_res <= '{K_NOFREE, 4'd0, 32'd0, 1'b0, 1'b1};
                    end
                end else begin
                    if (sel_ok) begin
                        r_busy[sel_ext[IW-1:0]] <= 1'b0;
                        r_res <= '{K_CANCELLED, r_in.slot_sel, 32'd0, 1'b0, 1'b1};
                    end else begin
                        r_res <= '{K_REJECTED, r_in.slot_sel, 32'd0, 1'b0, 1'b1};
                    end
                end
            end
            if (i_ctl.emit_done) begin
                r_res <= '{K_TICKDONE, 4'd0, r_wake, r_wvalid, 1'b1};
            end
        end
    end

    assign o_valid = o_valid_r;
    assign o_res   = r_res;

endmodule

@@ sv/multi_slot_timer_table.sv @@
// ----------------------------------------------------------------------------
// multi_slot_timer_table
// Pool of timer slots with start, cancel and tick commands.
// ----------------------------------------------------------------------------
//  channel | ports                      | handshake
//  command | i_start, i_cmd_in, o_busy  | taken when i_start && !o_busy
//  result  | o_res_valid, o_res         | one cycle strobe, no stall
//
// Start and cancel: busy in state S_ONE, result on the ports in the cycle after.
// Tick: a subtract pass over all slots, one pick sweep and an emit state per
// expired slot plus one final empty sweep, then a wakeup minimum pass and the
// done state; all passes share the single scan over the slot store. Each
// result shows in the cycle after its emit. Reset clears all slots to free.
module multi_slot_timer_table #(
    parameter int NUM_SLOTS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  mstt_pkg::t_in  i_cmd_in,
    output logic           o_busy,
    output logic           o_res_valid,
    output mstt_pkg::t_out o_res
);
    import mstt_pkg::*;

    t_ctl ctl;
    t_sts sts;

    mstt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_cmd   (i_cmd_in.cmd),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (o_busy)
    );

    mstt_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_cmd_in),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_valid (o_res_valid),
        .o_res   (o_res)
    );

endmodule

@@ sv/mstt_chk.sv @@
// ----------------------------------------------------------------------------
// mstt_chk
// Port-level checks on the timer table.
// ----------------------------------------------------------------------------
module mstt_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_start,
    input mstt_pkg::t_in  i_cmd_in,
    input logic           o_busy,
    input logic           o_res_valid,
    input mstt_pkg::t_out o_res
);
    import mstt_pkg::*;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_cmd_in.cmd != CMD_NONE |=> o_busy)
        else $error("accepted command did not raise busy");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last |-> !o_busy)
        else $error("busy during final result");

    a_expired_notlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind == K_EXPIRED |-> !o_res.last)
        else $error("expired result marked last");

    a_wake_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind != K_TICKDONE |-> !o_res.wakeup_valid)
        else $error("wakeup flag outside tick done");

endmodule

bind multi_slot_timer_table mstt_chk u_chk (.*);

@@ tb/mstt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstt_checker
// Watches the command and result channels of the timer table, models the
// slot pool and compares every result beat against the predicted one.
// ----------------------------------------------------------------------------
module mstt_checker #(
    parameter int NUM_SLOTS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  mstt_pkg::t_in  i_cmd_in,
    input  logic           i_busy,
    input  logic           i_res_valid,
    input  mstt_pkg::t_out i_res,
    output int             o_errors,
    output int             o_pending
);
    import mstt_pkg::*;

    logic [31:0] remain_ms [NUM_SLOTS];
    logic [31:0] reload_ms [NUM_SLOTS];
    logic        in_use    [NUM_SLOTS];
    t_out        expected_q [$];

    task automatic report(input string what, input t_out got, input t_out exp);
        $display("%0t mismatch %s: got k%0d s%0d w%0d v%0d l%0d exp k%0d s%0d w%0d v%0d l%0d",
                 $time, what, got.kind, got.slot, got.next_wakeup_ms, got.wakeup_valid,
                 got.last, exp.kind, exp.slot, exp.next_wakeup_ms, exp.wakeup_valid,
                 exp.last);
        o_errors++;
    endtask

    function automatic t_out beat(t_kind k, logic [3:0] s, logic [31:0] w, logic v,
                                  logic l);
        t_out r;
        r.kind = k;
        r.slot = s;
        r.next_wakeup_ms = w;
        r.wakeup_valid = v;
        r.last = l;
        return r;
    endfunction

    task automatic add_expected(input t_out b);
        expected_q.insert(expected_q.size(), b);
    endtask

    task automatic predict_timers(input t_in c);
        logic [31:0] prior [NUM_SLOTS];
        int          order [$];
        int          j;
        logic [31:0] wake;
        logic        found;
        found = 0;
        wake = '0;
        case (t_cmd'(c.cmd))
            CMD_START: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!in_use[i] && !found) begin
                        found = 1;
                        in_use[i] = 1;
                        remain_ms[i] = c.timeout_ms;
                        reload_ms[i] = c.period_ms;
                        add_expected(beat(K_STARTED, 4'(i), '0, 0, 1));
                    end
                end
                if (!found) add_expected(beat(K_NOFREE, '0, '0, 0, 1));
            end
            CMD_CANCEL: begin
                if (int'(c.slot_sel) < NUM_SLOTS && in_use[c.slot_sel]) begin
                    in_use[c.slot_sel] = 0;
                    add_expected(beat(K_CANCELLED, c.slot_sel, '0, 0, 1));
                end else begin
                    add_expected(beat(K_REJECTED, c.slot_sel, '0, 0, 1));
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (in_use[i]) begin
                        prior[i] = remain_ms[i];
                        remain_ms[i] -= (c.elapsed_ms < prior[i]) ? c.elapsed_ms : prior[i];
                        if (remain_ms[i] == 0) begin
                            j = order.size();
                            while (j > 0 && prior[order[j-1]] > prior[i]) j--;
                            order.insert(j, i);
                        end
                    end
                end
                foreach (order[k]) begin
                    add_expected(beat(K_EXPIRED, 4'(order[k]), '0, 0, 0));
                    if (reload_ms[order[k]] != 0) remain_ms[order[k]] = reload_ms[order[k]];
                    else in_use[order[k]] = 0;
                end
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (in_use[i] && (!found || remain_ms[i] < wake)) begin
                        wake = remain_ms[i];
                        found = 1;
                    end
                end
                add_expected(beat(K_TICKDONE, '0, wake, found, 1));
            end
            default: ;
        endcase
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_out exp;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) in_use[i] = 0;
            expected_q.delete();
        end else begin
            if (i_res_valid) begin
                if (expected_q.size() == 0) begin
                    report("unexpected beat", i_res, '0);
                end else begin
                    exp = expected_q.pop_front();
                    if (i_res.kind !== exp.kind) report("kind", i_res, exp);
                    else if (i_res.slot !== exp.slot) report("slot", i_res, exp);
                    else if (i_res.next_wakeup_ms !== exp.next_wakeup_ms)
                        report("wakeup", i_res, exp);
                    else if (i_res.wakeup_valid !== exp.wakeup_valid)
                        report("valid", i_res, exp);
                    else if (i_res.last !== exp.last) report("last", i_res, exp);
                end
            end
            if (i_start && !i_busy) predict_timers(i_cmd_in);
        end
        o_pending = expected_q.size();
    end
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives start, cancel, tick and no-op commands into the timer table with random
// gaps, mostly realistic timer traffic plus extremes, and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import mstt_pkg::*;

    localparam int NUM_SLOTS = 16;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_start;
    t_in    i_cmd_in;
    logic   o_busy;
    logic   o_res_valid;
    t_out   o_res;
    int     errors;
    int     pending;

    multi_slot_timer_table #(.NUM_SLOTS(NUM_SLOTS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_cmd_in(i_cmd_in),
        .o_busy(o_busy), .o_res_valid(o_res_valid), .o_res(o_res)
    );

    mstt_checker #(.NUM_SLOTS(NUM_SLOTS)) chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_cmd_in(i_cmd_in),
        .i_busy(o_busy), .i_res_valid(o_res_valid), .i_res(o_res),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [31:0] pick_ms();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 3));
            1: return $urandom;
            2: return 32'hFFFF_FFFF - 32'($urandom_range(0, 2));
            default: return 32'($urandom_range(1, 200));
        endcase
    endfunction

    task automatic send_cmd(input t_cmd c, input logic [31:0] tmo, input logic [31:0] per,
                            input logic [3:0] sel, input logic [31:0] ela);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        repeat (gap) @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        i_cmd_in.cmd = c;
        i_cmd_in.timeout_ms = tmo;
        i_cmd_in.period_ms = per;
        i_cmd_in.slot_sel = sel;
        i_cmd_in.elapsed_ms = ela;
        i_start = 1;
        @(negedge i_clk);
        i_start = 0;
        i_cmd_in = {2'($urandom), $urandom, $urandom, 4'($urandom), $urandom};
    endtask

    task automatic random_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            send_cmd(CMD_START, pick_ms(), ($urandom_range(0, 2) == 0) ? '0 : pick_ms(),
                     4'($urandom), $urandom);
        else if (r < 60)
            send_cmd(CMD_CANCEL, $urandom, $urandom, 4'($urandom), $urandom);
        else if (r < 97)
            send_cmd(CMD_TICK, $urandom, $urandom, 4'($urandom), pick_ms());
        else
            send_cmd(CMD_NONE, $urandom, $urandom, 4'($urandom), $urandom);
    endtask

    initial begin
        i_rst_n = 0;
        i_start = 0;
        i_cmd_in = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send_cmd(CMD_TICK, '0, '0, '0, 32'hFFFF_FFFF);
        send_cmd(CMD_CANCEL, '0, '0, 4'hF, '0);
        send_cmd(CMD_START, '0, '0, '0, '0);
        send_cmd(CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
        send_cmd(CMD_START, 32'd5, 32'd5, '0, '0);
        send_cmd(CMD_START, 32'd5, '0, '0, '0);
        send_cmd(CMD_START, 32'd3, 32'd7, '0, '0);
        send_cmd(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF);
        send_cmd(CMD_TICK, '0, '0, '0, '0);
        send_cmd(CMD_TICK, '0, '0, '0, 32'd5);
        send_cmd(CMD_CANCEL, '0, '0, 4'd1, '0);
        send_cmd(CMD_CANCEL, '0, '0, 4'd1, '0);
        for (int i = 0; i < 15; i++) send_cmd(CMD_START, 32'd9, 32'(i % 3), '0, '0);
        send_cmd(CMD_TICK, '0, '0, '0, 32'hFFFF_FFFF);
        send_cmd(CMD_TICK, '0, '0, '0, 32'hFFFF_FFFF);

        wait (pending == 0);
        repeat (60) @(negedge i_clk);

        for (int n = 0; n < 200; n++) begin
            random_cmd();
            if (n == 100) begin
                wait (pending == 0);
                @(negedge i_clk);
            end
        end

        wait (pending == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

@@ files.f @@
sv/mstt_pkg.sv
sv/mstt_ctrl.sv
sv/mstt_dp.sv
sv/multi_slot_timer_table.sv
sv/mstt_chk.sv
tb/mstt_checker.sv
tb/testbench.sv
